/* sv/kct_pkg.sv */
// Package for the keyed count table: field widths, table size, status codes
// and the request, response and control types. No dependencies.
package kct_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int KEY_BITS      = 16;
  localparam int COUNT_BITS    = 32;

  typedef enum logic [2:0] {
    ST_INCREMENTED  = 3'd0,
    ST_INSERTED     = 3'd1,
    ST_ZERO_IGNORED = 3'd2,
    ST_TABLE_FULL   = 3'd3,
    ST_DECREMENTED  = 3'd4,
    ST_REMOVED      = 3'd5,
    ST_ABSENT       = 3'd6
  } status_e;

  typedef enum logic {
    REQ_ADD    = 1'b0,
    REQ_REMOVE = 1'b1
  } req_type_e;

  typedef struct packed {
    logic                  req_type;
    logic [KEY_BITS-1:0]   item_key;
    logic [COUNT_BITS-1:0] amount;
  } req_t;

  typedef struct packed {
    status_e               status;
    logic [COUNT_BITS-1:0] result_count;
    logic                  saturated;
  } rsp_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [COUNT_BITS-1:0] count;
  } entry_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic apply;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } dp_stat_t;

endpackage

/* sv/kct_ctrl.sv */
// Controller for the keyed count table: sequences request load, table scan
// and update. Depends on kct_pkg.
module kct_ctrl
  import kct_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o,
  output logic     idle_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_EXEC  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (stat_i.out_free) begin
          cmd_o.apply = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign idle_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* sv/kct_dp.sv */
// Datapath for the keyed count table: entry memory, valid bits, scan
// tracking, count update and output register. Depends on kct_pkg.
module kct_dp
  import kct_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  req_t     in_req_i,
  input  dp_cmd_t  cmd_i,
  output dp_stat_t stat_o,
  input  logic     out_stall_i,
  output logic     out_valid_o,
  output rsp_t     out_rsp_o
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  entry_t mem [TABLE_ENTRIES];

  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;
  req_t                     req_q;
  logic [IDX_W-1:0]         idx_q;
  entry_t                   rd_q;
  logic [IDX_W-1:0]         rd_idx_q;
  logic                     rd_vld_q;
  logic                     hit_q, free_q;
  logic [IDX_W-1:0]         hit_idx_q, free_idx_q;
  logic [COUNT_BITS-1:0]    hit_cnt_q;
  logic                     out_valid_q;
  rsp_t                     out_q, rsp_d;

  logic                     we;
  logic [IDX_W-1:0]         waddr;
  entry_t                   wdata;
  logic [COUNT_BITS:0]      sum;
  logic                     match, empty;

  assign match = rd_vld_q && valid_q[rd_idx_q] && (rd_q.key == req_q.item_key);
  assign empty = rd_vld_q && !valid_q[rd_idx_q];
  assign sum   = {1'b0, hit_cnt_q} + {1'b0, req_q.amount};

  always_comb begin
    we      = 1'b0;
    waddr   = hit_idx_q;
    wdata   = '{key: req_q.item_key, count: '0};
    valid_d = valid_q;
    rsp_d   = '{status: ST_ABSENT, result_count: '0, saturated: 1'b0};
    if (req_q.req_type == REQ_ADD) begin
      if (hit_q) begin
        we                 = 1'b1;
        wdata.count        = sum[COUNT_BITS] ? COUNT_MAX : sum[COUNT_BITS-1:0];
        rsp_d.status       = ST_INCREMENTED;
        rsp_d.result_count = wdata.count;
        rsp_d.saturated    = sum[COUNT_BITS];
      end else if (req_q.amount == '0) begin
        rsp_d.status = ST_ZERO_IGNORED;
      end else if (!free_q) begin
        rsp_d.status = ST_TABLE_FULL;
      end else begin
        we                 = 1'b1;
        waddr              = free_idx_q;
        wdata.count        = req_q.amount;
        valid_d[free_idx_q] = 1'b1;
        rsp_d.status       = ST_INSERTED;
        rsp_d.result_count = req_q.amount;
      end
    end else begin
      if (!hit_q) begin
        rsp_d.status = ST_ABSENT;
      end else if (req_q.amount >= hit_cnt_q) begin
        valid_d[hit_idx_q] = 1'b0;
        rsp_d.status       = ST_REMOVED;
      end else begin
        we                 = 1'b1;
        wdata.count        = hit_cnt_q - req_q.amount;
        rsp_d.status       = ST_DECREMENTED;
        rsp_d.result_count = wdata.count;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply && we) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.scan) begin
      rd_q     <= mem[idx_q];
      rd_idx_q <= idx_q;
    end
    if (cmd_i.load) begin
      req_q <= in_req_i;
    end
    if (match && !hit_q) begin
      hit_idx_q <= rd_idx_q;
      hit_cnt_q <= rd_q.count;
    end
    if (empty && !free_q) begin
      free_idx_q <= rd_idx_q;
    end
    if (cmd_i.apply) begin
      out_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan;
      if (cmd_i.load) begin
        idx_q <= '0;
      end else if (cmd_i.scan) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.load || cmd_i.apply) begin
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else begin
        if (match) begin
          hit_q <= 1'b1;
        end
        if (empty) begin
          free_q <= 1'b1;
        end
      end
      if (cmd_i.apply) begin
        valid_q     <= valid_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.scan_last = (idx_q == IDX_W'(TABLE_ENTRIES - 1));
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;
  assign out_valid_o      = out_valid_q;
  assign out_rsp_o        = out_q;

  a_apply_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.apply |-> (!out_valid_q || !out_stall_i))
    else $error("update while output register is held");

  a_hit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_q |-> valid_q[hit_idx_q])
    else $error("matched slot is not valid");

  a_free_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q |-> !valid_q[free_idx_q])
    else $error("free slot is valid");

  a_apply_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.apply |-> (!rd_vld_q && !cmd_i.scan))
    else $error("update with a compare still pending");

endmodule

/* sv/keyed_count_table.sv */
// Top level of the keyed count table: joins the controller and datapath.
// Depends on kct_pkg, kct_ctrl and kct_dp.
//
// Usage: a request (in_req_i: add or remove, key, amount) enters on the
// input channel when in_valid_i is high and in_stall_o is low. Each request
// gives exactly one response on the output channel (out_rsp_o: status,
// count after the request, saturation flag), taken when out_valid_o is high
// and out_stall_i is low.
// A request scans all 64 table slots, one memory read a cycle; then the
// compare of the last read and the update follow, and the response is
// registered in the output register. A request is not taken while another
// is in progress: in_stall_o is low only while no request is in progress;
// a new request may be taken while the last response still waits in the
// output register.
// Reset clears all valid bits at once, so the table starts empty and takes
// requests in the first cycle after reset. When the receiver stalls, the
// response holds; a finished update waits until the output register is
// free and the input stays stalled meanwhile.
module keyed_count_table
  import kct_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     idle;

  kct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .idle_o     (idle)
  );

  kct_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o)
  );

  assign in_stall_o = !idle;

endmodule
